@@ src/decimal_length_prefixed_deframer_unit_macros.svh @@
`ifndef DECIMAL_LENGTH_PREFIXED_DEFRAMER_UNIT_MACROS_SVH
`define DECIMAL_LENGTH_PREFIXED_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DLPD_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// next-cycle implication, checked outside reset
`define DLPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

@@ src/dlpd_pkg.sv @@
`default_nettype none

package dlpd_pkg;

	localparam int unsigned LENGTH_BITS_DEFAULT = 32;
	localparam logic [31:0] MAX_FRAME_LENGTH_RESET = 32'd1048576;

	localparam logic [7:0] CHAR_KEEPALIVE = 8'h6B;
	localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [7:0] CHAR_ZERO      = 8'h30;
	localparam logic [7:0] CHAR_NINE      = 8'h39;

	typedef enum logic [1:0] {
		PH_LENGTH  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_ERROR   = 2'd2
	} phase_t;

endpackage

`default_nettype wire

@@ src/decimal_length_prefixed_deframer_unit.sv @@
`default_nettype none

// Deframes a byte stream of ASCII decimal length lines (digits, then a newline)
// each followed by that many payload bytes. Payload bytes leave one per transfer
// with m_tlast on the final byte of a frame; a zero length gives a single
// empty-frame transfer (m_tuser[0] and m_tlast set, data zero). A length above
// max_frame_length, or any byte other than a digit or newline in a length line
// (a 'k' keepalive before the first digit is skipped), gives one error transfer
// (m_tuser[1] set) and the block then drops every byte until reset. One byte is
// accepted per clock cycle: an input register feeds a single state update into
// an output register, and the input side stalls only while a result waits on
// the output side and the input register is full.
module decimal_length_prefixed_deframer_unit
	import dlpd_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // in_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_byte
	output logic             m_tlast,   // is_last
	output logic [1:0]       m_tuser,   // is_empty, is_error
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data   // max_frame_length
);

	localparam int unsigned ACC_W = LENGTH_BITS + 4;
	localparam int unsigned CMP_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

	logic [31:0] max_len_q;

	logic       valid_s1;
	logic [7:0] byte_s1;

	phase_t                 phase_q, phase_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d;
	logic                   digits_q, digits_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;

	logic       go;
	logic       res_valid;
	logic [7:0] res_byte;
	logic       res_last;
	logic       res_empty;
	logic       res_error;

	logic       is_digit;
	logic       is_nl;
	logic       is_keep;
	logic       too_long;
	logic       len_zero;
	logic       rem_one;
	logic [ACC_W-1:0] acc_ext;
	logic [ACC_W-1:0] acc_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_FRAME_LENGTH_RESET;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	assign go       = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign is_nl    = (byte_s1 == CHAR_NEWLINE);
	assign is_keep  = (byte_s1 == CHAR_KEEPALIVE) && !digits_q;
	assign too_long = CMP_W'(acc_q) > CMP_W'(max_len_q);
	assign len_zero = (acc_q == '0);
	assign rem_one  = (rem_q == LENGTH_BITS'(1));

	// acc * 10 + digit, saturating at all ones
	assign acc_ext  = ACC_W'(acc_q);
	assign acc_next = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(byte_s1[3:0]);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_PAYLOAD: begin
				if (rem_one) begin
					phase_d = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				if (is_keep || is_digit) begin
					phase_d = PH_LENGTH;
				end else if (is_nl) begin
					if (too_long) begin
						phase_d = PH_ERROR;
					end else if (!len_zero) begin
						phase_d = PH_PAYLOAD;
					end
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_ERROR: phase_d = PH_ERROR;
			default:  phase_d = PH_ERROR;
		endcase
	end

	always_comb begin
		acc_d     = acc_q;
		digits_d  = digits_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res_byte  = '0;
		res_last  = 1'b0;
		res_empty = 1'b0;
		res_error = 1'b0;
		case (phase_q)
			PH_PAYLOAD: begin
				rem_d     = rem_q - LENGTH_BITS'(1);
				res_valid = 1'b1;
				res_byte  = byte_s1;
				res_last  = rem_one;
			end
			PH_LENGTH: begin
				if (is_keep) begin
					res_valid = 1'b0;
				end else if (is_nl) begin
					acc_d    = '0;
					digits_d = 1'b0;
					if (too_long) begin
						res_valid = 1'b1;
						res_error = 1'b1;
					end else if (len_zero) begin
						res_valid = 1'b1;
						res_last  = 1'b1;
						res_empty = 1'b1;
					end else begin
						rem_d = acc_q;
					end
				end else if (is_digit) begin
					digits_d = 1'b1;
					if (acc_next[ACC_W-1:LENGTH_BITS] != '0) begin
						acc_d = '1;
					end else begin
						acc_d = acc_next[LENGTH_BITS-1:0];
					end
				end else begin
					acc_d     = '0;
					digits_d  = 1'b0;
					res_valid = 1'b1;
					res_error = 1'b1;
				end
			end
			PH_ERROR: res_valid = 1'b0;
			default:  res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LENGTH;
			acc_q    <= '0;
			digits_q <= 1'b0;
			rem_q    <= '0;
		end else if (go) begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			digits_q <= digits_d;
			rem_q    <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (go) begin
			m_tvalid <= res_valid;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			m_tdata <= res_byte;
			m_tlast <= res_last;
			m_tuser <= {res_error, res_empty};
		end
	end

`include "decimal_length_prefixed_deframer_unit_macros.svh"

	`DLPD_ASSERT_NEXT(a_error_sticky, phase_q == PH_ERROR, phase_q == PH_ERROR)
	`DLPD_ASSERT_IMPLIES(a_payload_count, phase_q == PH_PAYLOAD, rem_q != '0)
	`DLPD_ASSERT_IMPLIES(a_error_result, m_tvalid && m_tuser[1],
		!m_tlast && !m_tuser[0] && (m_tdata == 8'd0))
	`DLPD_ASSERT_IMPLIES(a_empty_result, m_tvalid && m_tuser[0],
		m_tlast && (m_tdata == 8'd0))

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none

module tb_top;
	import dlpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
		logic       error;
	} frame_beat_t;

	typedef enum int {
		BREAK_BAD_CHAR,
		BREAK_LATE_KEEPALIVE,
		BREAK_OVER_MAX,
		BREAK_SATURATED
	} break_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = 32'd0;

	logic [7:0]  raw_bytes[$];
	frame_beat_t pending_beats[$];
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          failures = 0;

	// shadow of the deframer state
	phase_t      state_phase = PH_LENGTH;
	logic [31:0] length_acc = 32'd0;
	logic        digits_seen = 1'b0;
	logic [31:0] bytes_left = 32'd0;
	logic [31:0] max_len = MAX_FRAME_LENGTH_RESET;

	decimal_length_prefixed_deframer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic deframe_byte(input logic [7:0] b);
		frame_beat_t beat;
		logic [31:0] digit;
		beat = '0;
		case (state_phase)
		PH_PAYLOAD: begin
			bytes_left = bytes_left - 32'd1;
			beat.data = b;
			if (bytes_left == 32'd0) begin
				beat.last = 1'b1;
				state_phase = PH_LENGTH;
			end
			pending_beats.push_back(beat);
		end
		PH_LENGTH: begin
			if (b == CHAR_KEEPALIVE && !digits_seen) begin
				// skipped
			end else if (b == CHAR_NEWLINE) begin
				if (length_acc > max_len) begin
					beat.error = 1'b1;
					state_phase = PH_ERROR;
					pending_beats.push_back(beat);
				end else if (length_acc == 32'd0) begin
					beat.last = 1'b1;
					beat.empty = 1'b1;
					pending_beats.push_back(beat);
				end else begin
					bytes_left = length_acc;
					state_phase = PH_PAYLOAD;
				end
				length_acc = 32'd0;
				digits_seen = 1'b0;
			end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
				digit = {24'd0, b - CHAR_ZERO};
				if (length_acc > (32'hFFFF_FFFF - digit) / 32'd10)
					length_acc = 32'hFFFF_FFFF;
				else
					length_acc = length_acc * 32'd10 + digit;
				digits_seen = 1'b1;
			end else begin
				beat.error = 1'b1;
				state_phase = PH_ERROR;
				length_acc = 32'd0;
				digits_seen = 1'b0;
				pending_beats.push_back(beat);
			end
		end
		default: begin
			// sticky error, byte dropped
		end
		endcase
	endtask

	// byte driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (raw_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= raw_bytes.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_beats.size() == 0) begin
					$display("%0t: unexpected transfer data=%h last=%b user=%b",
						$time, m_tdata, m_tlast, m_tuser);
					failures++;
				end else begin
					want = pending_beats.pop_front();
					if (m_tdata !== want.data) begin
						$display("%0t: data expected %h actual %h", $time, want.data, m_tdata);
						failures++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
						failures++;
					end
					if (m_tuser[0] !== want.empty) begin
						$display("%0t: empty expected %b actual %b",
							$time, want.empty, m_tuser[0]);
						failures++;
					end
					if (m_tuser[1] !== want.error) begin
						$display("%0t: error expected %b actual %b",
							$time, want.error, m_tuser[1]);
						failures++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic push_text(input string text);
		for (int i = 0; i < text.len(); i++)
			raw_bytes.push_back(text[i]);
	endtask

	task automatic queue_frame(input int unsigned len, input bit bare_line);
		int n;
		n = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) raw_bytes.push_back(CHAR_KEEPALIVE);
		if (!(bare_line && len == 0)) begin
			if ($urandom_range(7) == 0)
				repeat ($urandom_range(1, 3)) raw_bytes.push_back(CHAR_ZERO);
			push_text($sformatf("%0d", len));
		end
		raw_bytes.push_back(CHAR_NEWLINE);
		repeat (len) raw_bytes.push_back(8'($urandom_range(255)));
	endtask

	// sampled away from the rising edge so the driver's updates are settled
	task automatic drain_bytes();
		while (raw_bytes.size() != 0 || s_tvalid)
			@(negedge clk);
	endtask

	task automatic settle();
		drain_bytes();
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [31:0] value);
		settle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		max_len = value;
	endtask

	task automatic run_frames(input int target, input int unsigned cap,
			input int send_pct, input int stall_pct);
		int sent;
		int before_size;
		int unsigned len;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < target) begin
			if (cap == 0)
				len = 0;
			else if ($urandom_range(9) == 0)
				len = $urandom_range(cap);
			else
				len = $urandom_range(cap < 12 ? cap : 12);
			before_size = raw_bytes.size();
			queue_frame(len, 1'($urandom_range(1)));
			sent += raw_bytes.size() - before_size;
		end
		drain_bytes();
	endtask

	initial begin
		break_kind_t kind;
		logic [7:0] junk;
		logic [31:0] last_max;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset maximum
		push_text("\n");
		push_text("kk0\n");
		push_text("000\n");
		push_text("1\n");
		raw_bytes.push_back(8'h00);
		push_text("k3\n");
		raw_bytes.push_back(8'hFF);
		raw_bytes.push_back(CHAR_KEEPALIVE);
		raw_bytes.push_back(CHAR_NEWLINE);
		push_text("02\n");
		push_text("9k");
		drain_bytes();

		write_max_length(32'd0);
		run_frames(250, 0, 71, 0);

		write_max_length(32'hFFFF_FFFF);
		run_frames(300, 40, 0, 71);

		write_max_length(32'd5);
		queue_frame(5, 1'b0);
		run_frames(250, 5, 7, 7);

		last_max = $urandom_range(16, 300);
		write_max_length(last_max);
		run_frames(100, last_max, 0, 0);
		run_frames(100, last_max, 71, 0);
		run_frames(100, last_max, 0, 71);
		run_frames(100, last_max, 7, 7);

		// one framing error, then everything must be dropped
		kind = break_kind_t'($urandom_range(3));
		case (kind)
		BREAK_BAD_CHAR: begin
			if ($urandom_range(1))
				push_text($sformatf("%0d", $urandom_range(99)));
			do junk = 8'($urandom_range(255));
			while ((junk >= CHAR_ZERO && junk <= CHAR_NINE) || junk == CHAR_NEWLINE
				|| junk == CHAR_KEEPALIVE);
			raw_bytes.push_back(junk);
		end
		BREAK_LATE_KEEPALIVE: begin
			push_text("12k");
		end
		BREAK_OVER_MAX: begin
			push_text($sformatf("%0d\n", last_max + 1));
		end
		default: begin
			push_text("k99999999999999\n");
		end
		endcase
		push_text("0\n");
		repeat (40) raw_bytes.push_back(8'($urandom_range(255)));
		raw_bytes.push_back(8'h00);
		raw_bytes.push_back(8'hFF);
		drain_bytes();
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#3ms;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
